// ----- hw/rtl/eacpu_pkg.sv -----
package eacpu_pkg;

  typedef enum logic [1:0] {
    MODE_EXEC    = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_READ    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    OP_HALT, OP_BLT, OP_BGE, OP_ADD, OP_SUB, OP_SRL4, OP_SRL1, OP_SLL4, OP_SRL3,
    OP_INCH, OP_JFL, OP_CLRR, OP_NOP, OP_AND, OP_MOV, OP_LD, OP_LDN, OP_ST, OP_STN
  } op_e;

  localparam logic [7:0] OPC_HALT = 8'h00;
  localparam logic [7:0] OPC_BGE  = 8'h10;
  localparam logic [7:0] OPC_ADD  = 8'h20;
  localparam logic [7:0] OPC_SUB  = 8'h40;
  localparam logic [7:0] OPC_SRL4 = 8'h60;
  localparam logic [7:0] OPC_SRL1 = 8'h68;
  localparam logic [7:0] OPC_SLL4 = 8'h70;
  localparam logic [7:0] OPC_SRL3 = 8'h78;
  localparam logic [7:0] OPC_INCH = 8'h7C;
  localparam logic [7:0] OPC_JFL  = 8'h7D;
  localparam logic [7:0] OPC_CLRR = 8'h7E;
  localparam logic [7:0] OPC_NOPA = 8'h7F;
  localparam logic [7:0] OPC_MOV  = 8'hA0;
  localparam logic [7:0] OPC_LD   = 8'hC0;
  localparam logic [7:0] OPC_LDN  = 8'hD0;
  localparam logic [7:0] OPC_ST   = 8'hE0;
  localparam logic [7:0] OPC_STN  = 8'hF0;
  localparam logic [7:0] OPC_NOPB = 8'hFF;

  localparam logic [7:0] JFL_TARGET = 8'd14;

  localparam logic [2:0] REG_ZERO  = 3'd4;
  localparam logic [2:0] REG_ONE   = 3'd5;
  localparam logic [2:0] REG_THREE = 3'd6;
  localparam logic [2:0] REG_RES   = 3'd7;
  localparam logic [7:0] ONE_RST_VAL   = 8'd1;
  localparam logic [7:0] THREE_RST_VAL = 8'd3;

  typedef struct packed {
    logic [7:0] npc;
    logic       halted;
    logic       flag_we;
    logic       flag;
    logic       rwe;
    logic [2:0] ridx;
    logic [7:0] rval;
    logic       is_load;
    logic       dm_re;
    logic       dm_we;
    logic [7:0] dm_addr;
    logic [7:0] dm_wdata;
    logic       addr_ok;
    logic       mwe;
  } exe_res_t;

  function automatic op_e op_decode(logic [7:0] ins);
    op_e op;
    if (ins == OPC_HALT) op = OP_HALT;
    else if (ins < OPC_BGE) op = OP_BLT;
    else if (ins < OPC_ADD) op = OP_BGE;
    else if (ins < OPC_SUB) op = OP_ADD;
    else if (ins < OPC_SRL4) op = OP_SUB;
    else if (ins < OPC_SRL1) op = OP_SRL4;
    else if (ins < OPC_SLL4) op = OP_SRL1;
    else if (ins < OPC_SRL3) op = OP_SLL4;
    else if (ins < OPC_INCH) op = OP_SRL3;
    else if (ins == OPC_INCH) op = OP_INCH;
    else if (ins == OPC_JFL) op = OP_JFL;
    else if (ins == OPC_CLRR) op = OP_CLRR;
    else if (ins == OPC_NOPA || ins == OPC_NOPB) op = OP_NOP;
    else if (ins < OPC_MOV) op = OP_AND;
    else if (ins < OPC_LD) op = OP_MOV;
    else if (ins < OPC_LDN) op = OP_LD;
    else if (ins < OPC_ST) op = OP_LDN;
    else if (ins < OPC_STN) op = OP_ST;
    else op = OP_STN;
    return op;
  endfunction

  function automatic logic [2:0] rf_addr_a(logic [7:0] ins);
    logic [2:0] a;
    unique case (op_decode(ins))
      OP_ADD, OP_SUB:          a = ins[4:2];
      OP_SRL3:                 a = {1'b0, ins[1:0]};
      OP_INCH:                 a = REG_RES;
      OP_AND, OP_MOV:          a = {1'b0, ins[4:3]};
      OP_ST, OP_STN:           a = {1'b0, ins[3:2]};
      default:                 a = ins[2:0];
    endcase
    return a;
  endfunction

  function automatic logic [2:0] rf_addr_b(logic [7:0] ins);
    logic [2:0] b;
    unique case (op_decode(ins))
      OP_AND, OP_MOV: b = ins[2:0];
      default:        b = {1'b0, ins[1:0]};
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/eacpu_rf.sv -----
module eacpu_rf import eacpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       re_i,
  input  logic [2:0] raddr_a_i,
  input  logic [2:0] raddr_b_i,
  output logic [7:0] rdata_a_o,
  output logic [7:0] rdata_b_o,
  input  logic       we_i,
  input  logic [2:0] waddr_i,
  input  logic [7:0] wdata_i
);

  logic [7:0] rf_mem [8];
  logic [7:0] vld_q;
  logic [7:0] rd_a_q, rd_b_q;

  function automatic logic [7:0] rst_val(logic [2:0] idx);
    logic [7:0] v;
    if (idx == REG_ONE) v = ONE_RST_VAL;
    else if (idx == REG_THREE) v = THREE_RST_VAL;
    else v = 8'd0;
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rf_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= vld_q[raddr_a_i] ? rf_mem[raddr_a_i] : rst_val(raddr_a_i);
      rd_b_q <= vld_q[raddr_b_i] ? rf_mem[raddr_b_i] : rst_val(raddr_b_i);
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

// ----- hw/rtl/eacpu_dmem.sv -----
module eacpu_dmem #(
  parameter int DATA_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic       re_i,
  input  logic [7:0] addr_i,
  input  logic [7:0] wdata_i,
  output logic [7:0] rdata_o
);

  localparam int AW = $clog2(DATA_DEPTH);

  logic [7:0] mem [DATA_DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i[AW-1:0]] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[addr_i[AW-1:0]];
    end
  end

  assign rdata_o = rd_q;

endmodule

// ----- hw/rtl/eacpu_exec.sv -----
module eacpu_exec import eacpu_pkg::*; #(
  parameter int DATA_DEPTH = 256
) (
  input  mode_e      mode_i,
  input  logic [7:0] ins_i,
  input  logic [7:0] mem_index_i,
  input  logic [7:0] mem_data_i,
  input  logic [7:0] va_i,
  input  logic [7:0] vb_i,
  input  logic       flag_i,
  input  logic [7:0] pc_i,
  output exe_res_t   res_o
);

  localparam logic [8:0] DepthLim = 9'(DATA_DEPTH);

  op_e        op;
  logic [8:0] sum;
  logic [7:0] pc_inc;
  logic [7:0] ld_addr;
  logic [7:0] st_addr;
  logic       st_ok;

  assign op      = op_decode(ins_i);
  assign sum     = {1'b0, va_i} + {1'b0, vb_i};
  assign pc_inc  = pc_i + 8'd1;
  assign ld_addr = (op == OP_LDN) ? vb_i + 8'd1 : vb_i;
  assign st_addr = (op == OP_STN) ? va_i + 8'd1 : va_i;
  assign st_ok   = {1'b0, st_addr} < DepthLim;

  always_comb begin
    res_o = '0;
    res_o.npc = pc_i;
    unique case (mode_i)
      MODE_WRITE: begin
        res_o.dm_addr  = mem_index_i;
        res_o.dm_wdata = mem_data_i;
        res_o.addr_ok  = {1'b0, mem_index_i} < DepthLim;
        res_o.dm_we    = res_o.addr_ok;
      end
      MODE_READ: begin
        res_o.dm_addr = mem_index_i;
        res_o.addr_ok = {1'b0, mem_index_i} < DepthLim;
        res_o.dm_re   = 1'b1;
      end
      MODE_RESTART: begin
        res_o.npc = '0;
      end
      MODE_EXEC: begin
        res_o.npc = pc_inc;
        unique case (op)
          OP_HALT: res_o.halted = 1'b1;
          OP_BLT:  if (flag_i) res_o.npc = pc_i - {4'd0, ins_i[3:0]};
          OP_BGE:  if (flag_i) res_o.npc = pc_i + {4'd0, ins_i[3:0]};
          OP_ADD: begin
            res_o.rwe     = 1'b1;
            res_o.flag_we = 1'b1;
            res_o.flag    = sum[8];
            res_o.rval    = sum[7:0];
            res_o.ridx    = (ins_i[4:2] == REG_ZERO || ins_i[4:2] == REG_ONE ||
                             ins_i[4:2] == REG_THREE) ? {1'b0, ins_i[1:0]} : ins_i[4:2];
          end
          OP_SUB: begin
            res_o.rwe     = 1'b1;
            res_o.flag_we = 1'b1;
            res_o.flag    = va_i < vb_i;
            res_o.rval    = va_i - vb_i;
            res_o.ridx    = REG_RES;
          end
          OP_SRL4: begin
            res_o.rwe  = 1'b1;
            res_o.ridx = ins_i[2:0];
            res_o.rval = va_i >> 4;
          end
          OP_SRL1: begin
            res_o.rwe  = 1'b1;
            res_o.ridx = ins_i[2:0];
            res_o.rval = va_i >> 1;
          end
          OP_SLL4: begin
            res_o.rwe  = 1'b1;
            res_o.ridx = ins_i[2:0];
            res_o.rval = va_i << 4;
          end
          OP_SRL3: begin
            res_o.rwe  = 1'b1;
            res_o.ridx = {1'b0, ins_i[1:0]};
            res_o.rval = va_i >> 3;
          end
          OP_INCH: begin
            res_o.rwe  = 1'b1;
            res_o.ridx = REG_RES;
            res_o.rval = va_i + {7'd0, flag_i};
          end
          OP_JFL:  if (flag_i) res_o.npc = JFL_TARGET;
          OP_CLRR: begin
            res_o.rwe  = 1'b1;
            res_o.ridx = REG_RES;
          end
          OP_NOP: ;
          OP_AND, OP_MOV: begin
            res_o.rwe  = 1'b1;
            res_o.ridx = {1'b0, ins_i[4:3]};
            res_o.rval = (op == OP_AND) ? (va_i & vb_i) : vb_i;
          end
          OP_LD, OP_LDN: begin
            res_o.rwe     = 1'b1;
            res_o.ridx    = (op == OP_LDN) ? {1'b0, ins_i[3:2]} + 3'd1 : {1'b0, ins_i[3:2]};
            res_o.is_load = 1'b1;
            res_o.dm_re   = 1'b1;
            res_o.dm_addr = ld_addr;
            res_o.addr_ok = {1'b0, ld_addr} < DepthLim;
          end
          OP_ST, OP_STN: begin
            res_o.dm_addr  = st_addr;
            res_o.dm_wdata = vb_i;
            res_o.addr_ok  = st_ok;
            res_o.dm_we    = st_ok;
            res_o.mwe      = st_ok;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/eight_bit_accumulator_cpu_step_top.sv -----
// Path: an accepted beat moves through the input-stage registers, the result registers and the output register.
// Throughput: one beat per cycle while the output is not stalled; register read, then ALU/address
// with data memory read, then the output register, with forwarding from the two older register writes.
// Stall: the whole pipeline holds while the output register is full and stalled.
// Reset: registers 5 and 6 read 1 and 3, all others 0; flag, pc and count clear.
// Data memory contents are not cleared; an unwritten byte reads as undefined.
module eight_bit_accumulator_cpu_step_top import eacpu_pkg::*; #(
  parameter int DATA_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  instr_i,
  input  logic [7:0]  mem_index_i,
  input  logic [7:0]  mem_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  next_pc_o,
  output logic        halted_o,
  output logic        carry_flag_o,
  output logic        reg_we_o,
  output logic [2:0]  reg_index_o,
  output logic [7:0]  reg_value_o,
  output logic        mem_we_o,
  output logic [7:0]  store_addr_o,
  output logic [7:0]  store_value_o,
  output logic [7:0]  read_data_o,
  output logic [31:0] inst_count_o
);

  logic        adv;
  logic        v1_q, v2_q, out_valid_q;
  mode_e       mode1_q;
  logic [7:0]  ins1_q, midx1_q, mdat1_q;
  logic [2:0]  ra1_q, rb1_q;
  logic [7:0]  pc_q, pc_d;
  logic        flag_q, flag_d;
  logic [31:0] cnt_q, cnt_d;
  logic [7:0]  rf_a, rf_b, va, vb;
  logic [7:0]  dm_rd;
  exe_res_t    res, res2_q;
  logic [7:0]  pc2_q;
  logic        flag2_q;
  logic [31:0] cnt2_q;
  logic [7:0]  mem_val, wb_val, rd_out;
  logic        s2_wr;
  logic        lw_v_q;
  logic [2:0]  lw_idx_q;
  logic [7:0]  lw_val_q;

  logic [7:0]  out_pc_q, out_rval_q, out_saddr_q, out_sval_q, out_rdata_q;
  logic        out_halt_q, out_flag_q, out_rwe_q, out_mwe_q;
  logic [2:0]  out_ridx_q;
  logic [31:0] out_cnt_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  eacpu_rf u_rf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (adv),
    .raddr_a_i (rf_addr_a(instr_i)),
    .raddr_b_i (rf_addr_b(instr_i)),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b),
    .we_i      (adv && s2_wr),
    .waddr_i   (res2_q.ridx),
    .wdata_i   (wb_val)
  );

  assign mem_val = res2_q.addr_ok ? dm_rd : 8'd0;
  assign wb_val  = res2_q.is_load ? mem_val : res2_q.rval;
  assign rd_out  = (res2_q.dm_re && !res2_q.is_load) ? mem_val : 8'd0;
  assign s2_wr   = v2_q && res2_q.rwe;

  always_comb begin
    if (s2_wr && res2_q.ridx == ra1_q) va = wb_val;
    else if (lw_v_q && lw_idx_q == ra1_q) va = lw_val_q;
    else va = rf_a;
    if (s2_wr && res2_q.ridx == rb1_q) vb = wb_val;
    else if (lw_v_q && lw_idx_q == rb1_q) vb = lw_val_q;
    else vb = rf_b;
  end

  eacpu_exec #(.DATA_DEPTH(DATA_DEPTH)) u_exec (
    .mode_i      (mode1_q),
    .ins_i       (ins1_q),
    .mem_index_i (midx1_q),
    .mem_data_i  (mdat1_q),
    .va_i        (va),
    .vb_i        (vb),
    .flag_i      (flag_q),
    .pc_i        (pc_q),
    .res_o       (res)
  );

  eacpu_dmem #(.DATA_DEPTH(DATA_DEPTH)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (adv && v1_q && res.dm_we),
    .re_i    (adv && v1_q && res.dm_re),
    .addr_i  (res.dm_addr),
    .wdata_i (res.dm_wdata),
    .rdata_o (dm_rd)
  );

  always_comb begin
    pc_d   = res.npc;
    flag_d = res.flag_we ? res.flag : flag_q;
    unique case (mode1_q)
      MODE_EXEC:    cnt_d = cnt_q + 32'd1;
      MODE_RESTART: cnt_d = '0;
      default:      cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      lw_v_q      <= 1'b0;
      pc_q        <= '0;
      flag_q      <= 1'b0;
      cnt_q       <= '0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
      lw_v_q      <= s2_wr;
      if (v1_q) begin
        pc_q   <= pc_d;
        flag_q <= flag_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode1_q  <= mode_e'(mode_i);
      ins1_q   <= instr_i;
      midx1_q  <= mem_index_i;
      mdat1_q  <= mem_data_i;
      ra1_q    <= rf_addr_a(instr_i);
      rb1_q    <= rf_addr_b(instr_i);
      res2_q   <= res;
      pc2_q    <= pc_d;
      flag2_q  <= flag_d;
      cnt2_q   <= cnt_d;
      lw_idx_q <= res2_q.ridx;
      lw_val_q <= wb_val;
      out_pc_q    <= pc2_q;
      out_halt_q  <= res2_q.halted;
      out_flag_q  <= flag2_q;
      out_rwe_q   <= res2_q.rwe;
      out_ridx_q  <= res2_q.ridx;
      out_rval_q  <= wb_val;
      out_mwe_q   <= res2_q.mwe;
      out_saddr_q <= res2_q.mwe ? res2_q.dm_addr : 8'd0;
      out_sval_q  <= res2_q.mwe ? res2_q.dm_wdata : 8'd0;
      out_rdata_q <= rd_out;
      out_cnt_q   <= cnt2_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = out_pc_q;
  assign halted_o      = out_halt_q;
  assign carry_flag_o  = out_flag_q;
  assign reg_we_o      = out_rwe_q;
  assign reg_index_o   = out_ridx_q;
  assign reg_value_o   = out_rval_q;
  assign mem_we_o      = out_mwe_q;
  assign store_addr_o  = out_saddr_q;
  assign store_value_o = out_sval_q;
  assign read_data_o   = out_rdata_q;
  assign inst_count_o  = out_cnt_q;

  a_no_dual_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reg_we_o && mem_we_o))
    else $error("register and memory written by one beat");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && halted_o) |-> (!reg_we_o && !mem_we_o))
    else $error("halt beat reports a write");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v1_q && mode1_q == MODE_EXEC) |=> (cnt_q == $past(cnt_q) + 32'd1))
    else $error("instruction count did not advance");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(v1_q) && $stable(v2_q) && $stable(pc_q)))
    else $error("pipeline moved during stall");

endmodule

// ----- test/eight_bit_accumulator_cpu_step_top_tb.sv -----
module eight_bit_accumulator_cpu_step_top_tb import eacpu_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int RAND_BEATS  = 400;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [7:0]  npc;
    logic        halted;
    logic        carry;
    logic        rwe;
    logic [2:0]  ridx;
    logic [7:0]  rval;
    logic        mwe;
    logic [7:0]  saddr;
    logic [7:0]  sval;
    logic [7:0]  rdata;
    logic [31:0] icount;
  } step_out_t;

  class cpu_step_scoreboard;
    logic [7:0]  regs [8];
    logic        flag;
    logic [7:0]  pc;
    logic [31:0] icount;
    logic [7:0]  dmem [256];
    bit          written [256];
    step_out_t   step_results_q [$];
    int          mismatches;
    int          errors;
    int          n_exec, n_write, n_read, n_restart, n_checked;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      regs[REG_ONE]   = ONE_RST_VAL;
      regs[REG_THREE] = THREE_RST_VAL;
      flag = 1'b0;
      pc = 8'h00;
      icount = 32'h0;
      foreach (dmem[i]) begin
        dmem[i] = 8'h00;
        written[i] = 1'b0;
      end
      mismatches = 0;
      errors = 0;
      n_exec = 0;
      n_write = 0;
      n_read = 0;
      n_restart = 0;
      n_checked = 0;
    endfunction

    function bit reads_unwritten(mode_e m, logic [7:0] ins, logic [7:0] idx,
                                 output logic [7:0] addr);
      addr = idx;
      if (m == MODE_READ) return !written[idx];
      if (m != MODE_EXEC || ins < OPC_LD || ins >= OPC_ST) return 1'b0;
      addr = regs[ins[1:0]] + ((ins >= OPC_LDN) ? 8'd1 : 8'd0);
      return !written[addr];
    endfunction

    function void note_beat(mode_e m, logic [7:0] ins, logic [7:0] idx, logic [7:0] dat);
      step_out_t  e;
      logic [7:0] npc;
      logic [7:0] va;
      logic [7:0] vb;
      logic [7:0] addr;
      logic [8:0] sum;
      logic [2:0] a;
      logic [2:0] b;
      logic [2:0] d;
      e = '0;
      case (m)
        MODE_WRITE: begin
          dmem[idx] = dat;
          written[idx] = 1'b1;
          n_write++;
        end
        MODE_READ: begin
          e.rdata = dmem[idx];
          n_read++;
        end
        MODE_RESTART: begin
          pc = 8'h00;
          icount = 32'h0;
          n_restart++;
        end
        default: begin
          n_exec++;
          npc = pc + 8'd1;
          a = ins[4:2];
          b = {1'b0, ins[1:0]};
          if (ins == OPC_HALT) begin
            e.halted = 1'b1;
          end else if (ins < OPC_ADD) begin
            if (flag) npc = (ins < OPC_BGE) ? pc - {4'h0, ins[3:0]} : pc + {4'h0, ins[3:0]};
          end else if (ins < OPC_SUB) begin
            sum = {1'b0, regs[a]} + {1'b0, regs[b]};
            flag = sum[8];
            e.rwe = 1'b1;
            e.rval = sum[7:0];
            e.ridx = (a == REG_ZERO || a == REG_ONE || a == REG_THREE) ? b : a;
          end else if (ins < OPC_SRL4) begin
            e.rwe = 1'b1;
            e.rval = regs[a] - regs[b];
            e.ridx = REG_RES;
            flag = regs[a] < regs[b];
          end else if (ins < OPC_SRL3) begin
            e.rwe = 1'b1;
            e.ridx = ins[2:0];
            va = regs[ins[2:0]];
            if (ins < OPC_SRL1) e.rval = va >> 4;
            else if (ins < OPC_SLL4) e.rval = va >> 1;
            else e.rval = va << 4;
          end else if (ins < OPC_INCH) begin
            e.rwe = 1'b1;
            e.ridx = {1'b0, ins[1:0]};
            e.rval = regs[ins[1:0]] >> 3;
          end else if (ins == OPC_INCH) begin
            e.rwe = 1'b1;
            e.ridx = REG_RES;
            e.rval = regs[REG_RES] + {7'h0, flag};
          end else if (ins == OPC_JFL) begin
            if (flag) npc = JFL_TARGET;
          end else if (ins == OPC_CLRR) begin
            e.rwe = 1'b1;
            e.ridx = REG_RES;
            e.rval = 8'h00;
          end else if (ins == OPC_NOPA || ins == OPC_NOPB) begin
            e.rwe = 1'b0;
          end else if (ins < OPC_LD) begin
            d = {1'b0, ins[4:3]};
            vb = regs[ins[2:0]];
            e.rwe = 1'b1;
            e.ridx = d;
            e.rval = (ins < OPC_MOV) ? (regs[d] & vb) : vb;
          end else if (ins < OPC_ST) begin
            addr = regs[ins[1:0]];
            e.rwe = 1'b1;
            if (ins < OPC_LDN) begin
              e.ridx = {1'b0, ins[3:2]};
            end else begin
              e.ridx = {1'b0, ins[3:2]} + 3'd1;
              addr = addr + 8'd1;
            end
            e.rval = dmem[addr];
          end else begin
            addr = regs[ins[3:2]];
            if (ins >= OPC_STN) addr = addr + 8'd1;
            dmem[addr] = regs[ins[1:0]];
            written[addr] = 1'b1;
            e.mwe = 1'b1;
            e.saddr = addr;
            e.sval = regs[ins[1:0]];
          end
          if (e.rwe) regs[e.ridx] = e.rval;
          pc = npc;
          icount = icount + 32'd1;
        end
      endcase
      e.npc = pc;
      e.carry = flag;
      e.icount = icount;
      step_results_q = {step_results_q, e};
    endfunction

    function void check_result(step_out_t got);
      step_out_t e;
      if (step_results_q.size() == 0) begin
        errors++;
        $display("unexpected result beat: %p", got);
        return;
      end
      e = step_results_q.pop_front();
      n_checked++;
      if (got.npc !== e.npc || got.halted !== e.halted || got.carry !== e.carry ||
          got.rwe !== e.rwe || got.ridx !== e.ridx || got.rval !== e.rval ||
          got.mwe !== e.mwe || got.saddr !== e.saddr || got.sval !== e.sval ||
          got.rdata !== e.rdata || got.icount !== e.icount) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d", n_checked);
          $display("  expected: %p", e);
          $display("  actual:   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  instr_i;
  logic [7:0]  mem_index_i;
  logic [7:0]  mem_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  next_pc_o;
  logic        halted_o;
  logic        carry_flag_o;
  logic        reg_we_o;
  logic [2:0]  reg_index_o;
  logic [7:0]  reg_value_o;
  logic        mem_we_o;
  logic [7:0]  store_addr_o;
  logic [7:0]  store_value_o;
  logic [7:0]  read_data_o;
  logic [31:0] inst_count_o;

  cpu_step_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int beats_in;
  int quiet_cycles;
  int hold_left;
  bit hold_done;
  bit running;

  eight_bit_accumulator_cpu_step_top dut (.*);

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_beat(mode_e m, logic [7:0] ins, logic [7:0] idx, logic [7:0] dat);
    logic [7:0] addr;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    if (sb.reads_unwritten(m, ins, idx, addr)) begin
      m = MODE_WRITE;
      idx = addr;
    end
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    mode_i      = m;
    instr_i     = ins;
    mem_index_i = idx;
    mem_data_i  = dat;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(m, ins, idx, dat);
    beats_in++;
  endtask

  task automatic send_random_beat();
    int   pick;
    mode_e m;
    pick = $urandom_range(99);
    if (pick < 66) m = MODE_EXEC;
    else if (pick < 81) m = MODE_WRITE;
    else if (pick < 95) m = MODE_READ;
    else m = MODE_RESTART;
    send_beat(m, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (!hold_done && beats_in >= 320) begin
        out_stall_i = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else begin
        out_stall_i = ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{next_pc_o, halted_o, carry_flag_o, reg_we_o, reg_index_o,
                        reg_value_o, mem_we_o, store_addr_o, store_value_o,
                        read_data_o, inst_count_o});
    end
  end

  always @(posedge clk_i) begin
    if (running) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("eight_bit_accumulator_cpu_step_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int waited;
    sb = new();
    tx_idle_pct = 27;
    rx_idle_pct = 45;
    beats_in = 0;
    quiet_cycles = 0;
    running = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_EXEC;
    instr_i = 8'h00;
    mem_index_i = 8'h00;
    mem_data_i = 8'h00;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    running = 1'b1;

    send_beat(MODE_WRITE, 8'h00, 8'h00, 8'hFF);
    send_beat(MODE_WRITE, 8'hFF, 8'hFF, 8'h00);
    send_beat(MODE_WRITE, 8'h00, 8'h01, 8'h80);
    send_beat(MODE_READ,  8'h00, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  OPC_HALT, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'hC4, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h25, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h0F, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h1F, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  OPC_JFL, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  OPC_INCH, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h35, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h4D, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h61, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h6F, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h77, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h7B, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  OPC_CLRR, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  OPC_NOPA, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  OPC_NOPB, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'h9F, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'hBD, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'hC4, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'hD1, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'hF5, 8'h00, 8'h00);
    send_beat(MODE_EXEC,  8'hEF, 8'h00, 8'h00);
    send_beat(MODE_RESTART, 8'hFF, 8'hFF, 8'hFF);

    repeat (RAND_BEATS / 3) send_random_beat();
    tx_idle_pct = 45;
    rx_idle_pct = 27;
    repeat (RAND_BEATS / 3) send_random_beat();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (RAND_BEATS - 2 * (RAND_BEATS / 3)) send_random_beat();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    waited = 0;
    while (sb.step_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.step_results_q.size() != 0) begin
      $display("timeout: %0d results still outstanding", sb.step_results_q.size());
      $display("eight_bit_accumulator_cpu_step_top_tb: errors");
    end else begin
      repeat (8) @(posedge clk_i);
      $display("covered %0d beats: %0d executed, %0d data writes, %0d reads, %0d restarts",
               beats_in, sb.n_exec, sb.n_write, sb.n_read, sb.n_restart);
      $display("checked %0d results, %0d mismatches, %0d errors in all",
               sb.n_checked, sb.mismatches, sb.errors);
      if (sb.errors == 0 && sb.step_results_q.size() == 0) begin
        $display("eight_bit_accumulator_cpu_step_top_tb: clean");
      end else begin
        $display("eight_bit_accumulator_cpu_step_top_tb: errors");
      end
    end
    $finish;
  end

endmodule

// ----- eight_bit_accumulator_cpu_step_top.f -----
hw/rtl/eacpu_pkg.sv
hw/rtl/eacpu_rf.sv
hw/rtl/eacpu_dmem.sv
hw/rtl/eacpu_exec.sv
hw/rtl/eight_bit_accumulator_cpu_step_top.sv
test/eight_bit_accumulator_cpu_step_top_tb.sv
